FILE: rtl/gqa_pkg.sv
// Shared types and constants of the grouped-query attention step block.
// Holds item action codes, register indexes, the controller/datapath
// command and status words and the exponential lookup table.
package gqa_pkg;

   // action codes of an input word
   localparam logic [1:0] ACT_WR_QUERY = 2'd0;
   localparam logic [1:0] ACT_WR_KEY   = 2'd1;
   localparam logic [1:0] ACT_WR_VALUE = 2'd2;
   localparam logic [1:0] ACT_RUN      = 2'd3;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_HEAD_COUNT  = 2'd0;
   localparam logic [1:0] CSR_GROUP_SIZE  = 2'd1;
   localparam logic [1:0] CSR_HEAD_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_SCORE_SCALE = 2'd3;

   localparam int EXP_ENTRIES = 1024;
   localparam int DOT_W       = 39;   // 64 products of Q8.24
   localparam int PROD_W      = 55;   // dot times unsigned Q0.16 scale
   localparam int ACC_W       = 42;   // up to 128 weight-value products

   typedef logic [15:0] exp_table_type [EXP_ENTRIES];

   typedef struct packed {
      logic write_item;
      logic start_run;
      logic err_load;
      logic rd_qk;
      logic mac_dot;
      logic mul_score;
      logic wr_score;
      logic rd_score;
      logic exp_lookup;
      logic exp_acc;
      logic div_load;
      logic div_step;
      logic wr_quot;
      logic rd_wv;
      logic mac_out;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic run_bad;
      logic t_last;
      logic d_last;
      logic div_last;
      logic out_free;
   } stat_type;

   // exp(-k/64) in Q0.16 built by a Q0.32 recurrence
   function automatic exp_table_type build_exp();
      exp_table_type tbl;
      logic [63:0]   acc;
      logic [63:0]   e;
      acc = 64'h1_0000_0000;
      for (int i = 0; i < EXP_ENTRIES; i++) begin
         if (i > 0) begin
            acc = (acc * 64'd4228380000 + 64'h8000_0000) >> 32;
         end
         e = (acc + 64'd32768) >> 16;
         tbl[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
      end
      return tbl;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp();

endpackage

FILE: rtl/gqa_control.sv
// Sequencer of the grouped-query attention step block.
// Depends on gqa_pkg for the command and status words.
module gqa_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  gqa_pkg::stat_type stat,
   output gqa_pkg::cmd_type  cmd
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_ERR      = 5'd1;
   localparam logic [4:0] S_SC_RD    = 5'd2;
   localparam logic [4:0] S_SC_MAC   = 5'd3;
   localparam logic [4:0] S_SC_MUL   = 5'd4;
   localparam logic [4:0] S_SC_WR    = 5'd5;
   localparam logic [4:0] S_EX_RD    = 5'd6;
   localparam logic [4:0] S_EX_LK    = 5'd7;
   localparam logic [4:0] S_EX_ACC   = 5'd8;
   localparam logic [4:0] S_DV_RD    = 5'd9;
   localparam logic [4:0] S_DV_LD    = 5'd10;
   localparam logic [4:0] S_DV_RUN   = 5'd11;
   localparam logic [4:0] S_DV_WR    = 5'd12;
   localparam logic [4:0] S_OUT_RD   = 5'd13;
   localparam logic [4:0] S_OUT_MAC  = 5'd14;
   localparam logic [4:0] S_OUT_EMIT = 5'd15;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == gqa_pkg::ACT_RUN) begin
                  cmd.start_run = 1'b1;
                  state_in = stat.run_bad ? S_ERR : S_SC_RD;
               end else begin
                  cmd.write_item = 1'b1;
               end
            end
         end
         S_ERR: begin
            if (stat.out_free) begin
               cmd.err_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SC_RD: begin
            cmd.rd_qk = 1'b1;
            state_in = S_SC_MAC;
         end
         S_SC_MAC: begin
            cmd.mac_dot = 1'b1;
            state_in = stat.d_last ? S_SC_MUL : S_SC_RD;
         end
         S_SC_MUL: begin
            cmd.mul_score = 1'b1;
            state_in = S_SC_WR;
         end
         S_SC_WR: begin
            cmd.wr_score = 1'b1;
            state_in = stat.t_last ? S_EX_RD : S_SC_RD;
         end
         S_EX_RD: begin
            cmd.rd_score = 1'b1;
            state_in = S_EX_LK;
         end
         S_EX_LK: begin
            cmd.exp_lookup = 1'b1;
            state_in = S_EX_ACC;
         end
         S_EX_ACC: begin
            cmd.exp_acc = 1'b1;
            state_in = stat.t_last ? S_DV_RD : S_EX_RD;
         end
         S_DV_RD: begin
            cmd.rd_score = 1'b1;
            state_in = S_DV_LD;
         end
         S_DV_LD: begin
            cmd.div_load = 1'b1;
            state_in = S_DV_RUN;
         end
         S_DV_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_DV_WR;
            end
         end
         S_DV_WR: begin
            cmd.wr_quot = 1'b1;
            state_in = stat.t_last ? S_OUT_RD : S_DV_RD;
         end
         S_OUT_RD: begin
            cmd.rd_wv = 1'b1;
            state_in = S_OUT_MAC;
         end
         S_OUT_MAC: begin
            cmd.mac_out = 1'b1;
            state_in = stat.t_last ? S_OUT_EMIT : S_OUT_RD;
         end
         S_OUT_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.d_last ? S_IDLE : S_OUT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.err_load) |-> stat.out_free)
      else $error("result loaded while output register busy");
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DV_RUN && stat.div_last) |=> state_ff == S_DV_WR)
      else $error("divider did not hand over its quotient");
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && stat.d_last) |=> state_ff == S_IDLE)
      else $error("run did not end after its last element");
`endif

endmodule

FILE: rtl/gqa_datapath.sv
// Datapath of the grouped-query attention step block: stores, registers,
// multiply-accumulate, exp lookup, divider and the output register.
// Depends on gqa_pkg for the command and status words and the exp table.
module gqa_datapath #(
   parameter int HEADS_MAX     = 8,
   parameter int HEAD_SIZE_MAX = 64,
   parameter int SEQ_MAX       = 128,
   parameter int KV_DIM_MAX    = 256,
   parameter int LAYERS        = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_action,
   input  logic [1:0]         req_layer,
   input  logic [6:0]         req_position,
   input  logic [2:0]         req_head,
   input  logic [5:0]         req_element,
   input  logic signed [15:0] req_sample,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_out_head,
   output logic [5:0]         rsp_out_element,
   output logic signed [15:0] rsp_out_value,
   output logic               rsp_last,
   output logic               rsp_status,
   input  gqa_pkg::cmd_type   cmd,
   output gqa_pkg::stat_type  stat
);

   localparam int QDEPTH  = HEADS_MAX * HEAD_SIZE_MAX;
   localparam int KVDEPTH = LAYERS * SEQ_MAX * KV_DIM_MAX;
   localparam int QAW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int KVAW    = (KVDEPTH > 1) ? $clog2(KVDEPTH) : 1;
   localparam int SAW     = (SEQ_MAX > 1) ? $clog2(SEQ_MAX) : 1;
   localparam int DW      = gqa_pkg::DOT_W;
   localparam int PW      = gqa_pkg::PROD_W;
   localparam int AW      = gqa_pkg::ACC_W;

   function automatic logic [2:0] kv_head(input logic [2:0] h, input logic [3:0] g);
      logic [2:0] q;
      q = 3'd0;
      for (int k = 1; k < 8; k++) begin
         if (7'(k) * 7'(g) <= 7'(h)) begin
            q = q + 3'd1;
         end
      end
      return q;
   endfunction

   // stores
   logic signed [15:0] query_mem [QDEPTH];
   logic signed [15:0] key_mem   [KVDEPTH];
   logic signed [15:0] value_mem [KVDEPTH];
   logic [31:0]        score_mem [SEQ_MAX];

   // configuration
   logic [3:0]  head_count_ff;
   logic [3:0]  group_size_ff;
   logic [6:0]  head_width_ff;
   logic [15:0] score_scale_ff;

   // run state
   logic [1:0]           layer_ff, layer_in;
   logic [6:0]           pos_ff, pos_in;
   logic [2:0]           head_ff, head_in;
   logic [9:0]           kvoff_ff, kvoff_in;
   logic [6:0]           t_ff, t_in;
   logic [6:0]           d_ff, d_in;
   logic signed [DW-1:0] dot_ff, dot_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [31:0]   max_ff, max_in;
   logic [31:0]          sum_ff, sum_in;
   logic [32:0]          num_ff, num_in;
   logic [32:0]          rem_ff, rem_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           out_head_ff, out_head_in;
   logic [5:0]           out_element_ff, out_element_in;
   logic signed [15:0]   out_value_ff, out_value_in;
   logic                 last_ff, last_in;
   logic                 status_ff, status_in;

   // read data
   logic signed [15:0] q_rd_ff, k_rd_ff, v_rd_ff;
   logic [31:0]        sb_rd_ff;
   logic [15:0]        exp_rd_ff;

   logic [6:0]           hw_eff;
   logic [3:0]           grp_eff;
   logic [10:0]          wr_off;
   logic                 kv_ok, q_we, k_we, v_we;
   logic [QAW-1:0]       q_wa, q_ra;
   logic [KVAW-1:0]      kv_wa, kv_ra;
   logic [SAW-1:0]       sb_a;
   logic                 sb_we;
   logic [31:0]          sb_wd;
   logic [2:0]           run_kvh;
   logic [9:0]           run_kvoff;
   logic                 t_last, d_last, out_free;
   logic [6:0]           t_next;
   logic signed [PW-1:0] prod_rnd;
   logic signed [31:0]   score_new;
   logic [32:0]          diff_rnd;
   logic [9:0]           exp_idx;
   logic [32:0]          trial;
   logic                 ge;
   logic signed [31:0]   qk;
   logic signed [33:0]   wv;
   logic signed [AW-1:0] out_rnd;
   logic signed [15:0]   out_sat;

   // effective register values
   always_comb begin
      if (head_width_ff == 7'd0) begin
         hw_eff = 7'd1;
      end else if (int'(head_width_ff) > HEAD_SIZE_MAX) begin
         hw_eff = 7'(HEAD_SIZE_MAX);
      end else begin
         hw_eff = head_width_ff;
      end
      grp_eff = (group_size_ff == 4'd0) ? 4'd1 : group_size_ff;
   end

   // write path: drop writes that fall outside the stores, and key/value writes past the head width
   assign wr_off = 11'(req_head) * 11'(hw_eff) + 11'(req_element);
   assign kv_ok  = int'(req_layer) < LAYERS && int'(req_position) < SEQ_MAX &&
                   {1'b0, req_element} < hw_eff && int'(wr_off) < KV_DIM_MAX;
   assign q_we   = cmd.write_item && req_action == gqa_pkg::ACT_WR_QUERY &&
                   int'(req_head) < HEADS_MAX && int'(req_element) < HEAD_SIZE_MAX;
   assign k_we   = cmd.write_item && req_action == gqa_pkg::ACT_WR_KEY && kv_ok;
   assign v_we   = cmd.write_item && req_action == gqa_pkg::ACT_WR_VALUE && kv_ok;
   assign q_wa   = QAW'(int'(req_head) * HEAD_SIZE_MAX + int'(req_element));
   assign kv_wa  = KVAW'((int'(req_layer) * SEQ_MAX + int'(req_position)) * KV_DIM_MAX +
                         int'(wr_off));

   // run check
   assign run_kvh   = kv_head(req_head, grp_eff);
   assign run_kvoff = 10'(run_kvh) * 10'(hw_eff);
   assign stat.run_bad = ({1'b0, req_head} >= head_count_ff) ||
                         int'(req_head) >= HEADS_MAX || int'(req_layer) >= LAYERS ||
                         int'(req_position) >= SEQ_MAX ||
                         int'(run_kvoff) + int'(hw_eff) > KV_DIM_MAX;

   // run addresses
   assign q_ra = QAW'(int'(head_ff) * HEAD_SIZE_MAX + int'(d_ff));
   assign kv_ra = KVAW'((int'(layer_ff) * SEQ_MAX + int'(t_ff)) * KV_DIM_MAX +
                        int'(kvoff_ff) + int'(d_ff));
   assign sb_a = SAW'(t_ff);

   assign t_last   = (t_ff == pos_ff);
   assign d_last   = (d_ff == hw_eff - 7'd1);
   assign t_next   = t_last ? 7'd0 : t_ff + 7'd1;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign stat.t_last   = t_last;
   assign stat.d_last   = d_last;
   assign stat.div_last = (cnt_ff == 6'd32);
   assign stat.out_free = out_free;

   // arithmetic
   always_comb begin
      qk        = q_rd_ff * k_rd_ff;
      prod_rnd  = (prod_ff + PW'(64'sd8388608)) >>> 24;
      score_new = prod_rnd[31:0];
      diff_rnd  = {max_ff[31], max_ff} - {sb_rd_ff[31], sb_rd_ff} + 33'd512;
      exp_idx   = (|diff_rnd[32:20]) ? 10'd1023 : diff_rnd[19:10];
      trial     = {rem_ff[31:0], num_ff[32]};
      ge        = trial >= {1'b0, sum_ff};
      wv        = $signed({1'b0, sb_rd_ff[16:0]}) * v_rd_ff;
      out_rnd   = (acc_ff + AW'(64'sd32768)) >>> 16;
      if (out_rnd > AW'(64'sd32767)) begin
         out_sat = 16'sh7FFF;
      end else if (out_rnd < -AW'(64'sd32768)) begin
         out_sat = -16'sh8000;
      end else begin
         out_sat = out_rnd[15:0];
      end
   end

   // score buffer write port
   always_comb begin
      sb_we = cmd.wr_score || cmd.exp_acc || cmd.wr_quot;
      if (cmd.wr_score) begin
         sb_wd = score_new;
      end else if (cmd.exp_acc) begin
         sb_wd = {16'd0, exp_rd_ff};
      end else begin
         sb_wd = num_ff[31:0];
      end
   end

   // next values
   always_comb begin
      layer_in       = layer_ff;
      pos_in         = pos_ff;
      head_in        = head_ff;
      kvoff_in       = kvoff_ff;
      t_in           = t_ff;
      d_in           = d_ff;
      dot_in         = dot_ff;
      prod_in        = prod_ff;
      max_in         = max_ff;
      sum_in         = sum_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      acc_in         = acc_ff;
      out_head_in    = out_head_ff;
      out_element_in = out_element_ff;
      out_value_in   = out_value_ff;
      last_in        = last_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (cmd.start_run) begin
         layer_in = req_layer;
         pos_in   = req_position;
         head_in  = req_head;
         kvoff_in = run_kvoff;
         t_in     = 7'd0;
         d_in     = 7'd0;
         dot_in   = '0;
         acc_in   = '0;
         sum_in   = 32'd0;
      end
      if (cmd.mac_dot) begin
         dot_in = dot_ff + DW'(qk);
         d_in   = d_ff + 7'd1;
      end
      if (cmd.mul_score) begin
         prod_in = dot_ff * $signed({1'b0, score_scale_ff});
      end
      if (cmd.wr_score) begin
         if (t_ff == 7'd0 || score_new > max_ff) begin
            max_in = score_new;
         end
         dot_in = '0;
         d_in   = 7'd0;
         t_in   = t_next;
      end
      if (cmd.exp_acc) begin
         sum_in = sum_ff + {16'd0, exp_rd_ff};
         t_in   = t_next;
      end
      if (cmd.div_load) begin
         num_in = {1'b0, sb_rd_ff[15:0], 16'd0} + {2'b0, sum_ff[31:1]};
         rem_in = 33'd0;
         cnt_in = 6'd0;
      end
      if (cmd.div_step) begin
         rem_in = ge ? trial - {1'b0, sum_ff} : trial;
         num_in = {num_ff[31:0], ge};
         cnt_in = cnt_ff + 6'd1;
      end
      if (cmd.wr_quot) begin
         t_in = t_next;
      end
      if (cmd.mac_out) begin
         acc_in = acc_ff + AW'(wv);
         t_in   = t_next;
      end
      if (cmd.emit) begin
         out_head_in    = head_ff;
         out_element_in = d_ff[5:0];
         out_value_in   = out_sat;
         last_in        = d_last;
         status_in      = 1'b0;
         rsp_valid_in   = 1'b1;
         d_in           = d_ff + 7'd1;
         acc_in         = '0;
      end
      if (cmd.err_load) begin
         out_head_in    = head_ff;
         out_element_in = 6'd0;
         out_value_in   = 16'sd0;
         last_in        = 1'b1;
         status_in      = 1'b1;
         rsp_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         sum_ff         <= 32'd0;
         head_count_ff  <= 4'd1;
         group_size_ff  <= 4'd1;
         head_width_ff  <= 7'd64;
         score_scale_ff <= 16'd8192;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         if (csr_write_enable) begin
            case (csr_index)
               gqa_pkg::CSR_HEAD_COUNT:  head_count_ff  <= csr_data[3:0];
               gqa_pkg::CSR_GROUP_SIZE:  group_size_ff  <= csr_data[3:0];
               gqa_pkg::CSR_HEAD_WIDTH:  head_width_ff  <= csr_data[6:0];
               gqa_pkg::CSR_SCORE_SCALE: score_scale_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      layer_ff       <= layer_in;
      pos_ff         <= pos_in;
      head_ff        <= head_in;
      kvoff_ff       <= kvoff_in;
      t_ff           <= t_in;
      d_ff           <= d_in;
      dot_ff         <= dot_in;
      prod_ff        <= prod_in;
      max_ff         <= max_in;
      num_ff         <= num_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      acc_ff         <= acc_in;
      out_head_ff    <= out_head_in;
      out_element_ff <= out_element_in;
      out_value_ff   <= out_value_in;
      last_ff        <= last_in;
      status_ff      <= status_in;
   end

   // memories
   always_ff @(posedge clock) begin
      if (q_we) begin
         query_mem[q_wa] <= req_sample;
      end
      if (cmd.rd_qk) begin
         q_rd_ff <= query_mem[q_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (k_we) begin
         key_mem[kv_wa] <= req_sample;
      end
      if (cmd.rd_qk) begin
         k_rd_ff <= key_mem[kv_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         value_mem[kv_wa] <= req_sample;
      end
      if (cmd.rd_wv) begin
         v_rd_ff <= value_mem[kv_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (sb_we) begin
         score_mem[sb_a] <= sb_wd;
      end
      if (cmd.rd_score || cmd.rd_wv) begin
         sb_rd_ff <= score_mem[sb_a];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exp_lookup) begin
         exp_rd_ff <= gqa_pkg::EXP_TABLE[exp_idx];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_head    = out_head_ff;
   assign rsp_out_element = out_element_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_last        = last_ff;
   assign rsp_status      = status_ff;

endmodule

FILE: rtl/grouped_query_attention_step.sv
// Top level of the grouped-query attention step block.
// Depends on gqa_pkg, gqa_control and gqa_datapath.
//
// Usage:
//  - req_ channel (valid/ready) carries one word per item: query, key or
//    value writes, or a run naming layer, query head and last position p.
//  - A write does not leave the idle state; req_ready stays high.
//  - A run walks all positions 0..p in these passes:
//      scores   a scaled W-element dot product per position, W = effective head width
//      exp      one lookup per position through the exp table
//      weights  one quotient per position from the one-bit-a-step divider
//      outputs  one result word per element, summed over all positions
//  - A bad run yields one status word, loaded from the error state once the output register is free.
//  - rsp_ words sit in an output register; a stalled receiver holds the
//    run at its next element and the block resumes when the word is taken.
//    Writes are still accepted while the last word of a run waits.
//  - csr_ writes are registered; write them only while the block idles.
//  - Reset (synchronous) empties the output register and restores the
//    register defaults; store contents stay undefined until written.
module grouped_query_attention_step #(
   parameter int HEADS_MAX     = 8,
   parameter int HEAD_SIZE_MAX = 64,
   parameter int SEQ_MAX       = 128,
   parameter int KV_DIM_MAX    = 256,
   parameter int LAYERS        = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [1:0]         req_layer,
   input  logic [6:0]         req_position,
   input  logic [2:0]         req_head,
   input  logic [5:0]         req_element,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_out_head,
   output logic [5:0]         rsp_out_element,
   output logic signed [15:0] rsp_out_value,
   output logic               rsp_last,
   output logic               rsp_status,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   // command word down to the datapath, status back up
   gqa_pkg::cmd_type  cmd;
   gqa_pkg::stat_type stat;

   gqa_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   gqa_datapath #(
      .HEADS_MAX     (HEADS_MAX),
      .HEAD_SIZE_MAX (HEAD_SIZE_MAX),
      .SEQ_MAX       (SEQ_MAX),
      .KV_DIM_MAX    (KV_DIM_MAX),
      .LAYERS        (LAYERS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_action),
      .req_layer        (req_layer),
      .req_position     (req_position),
      .req_head         (req_head),
      .req_element      (req_element),
      .req_sample       (req_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_head     (rsp_out_head),
      .rsp_out_element  (rsp_out_element),
      .rsp_out_value    (rsp_out_value),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of grouped_query_attention_step: drives cache, query and run
// words, predicts every result word in the bench and compares them as they arrive.
// Depends on gqa_pkg and the grouped_query_attention_step RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gqa_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int ITEM_TARGET = 320;

   typedef struct {
      logic [2:0]         head;
      logic [5:0]         elem;
      logic signed [15:0] value;
      logic               last;
      logic               status;
   } attn_word_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = ACT_WR_QUERY;
   logic [1:0]         req_layer = '0;
   logic [6:0]         req_position = '0;
   logic [2:0]         req_head = '0;
   logic [5:0]         req_element = '0;
   logic signed [15:0] req_sample = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_out_head;
   logic [5:0]         rsp_out_element;
   logic signed [15:0] rsp_out_value;
   logic               rsp_last;
   logic               rsp_status;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = CSR_HEAD_COUNT;
   logic [15:0]        csr_data = '0;

   // mirror of the block's registers and stores; an entry exists once written
   int                        cfg_heads = 1, cfg_group = 1, cfg_width = 64, cfg_scale = 8192;
   logic signed [15:0]        query_mem [int];
   logic signed [15:0]        key_mem [int];
   logic signed [15:0]        val_mem [int];
   logic [15:0]               exp_lut [1024];
   attn_word_t                pending_words [$];

   int  cycles = 0, mismatches = 0;
   int  n_items = 0, n_runs = 0, n_bad_runs = 0, n_words = 0;
   bit  no_idle = 0, tx_quiet = 0, hold_request = 0;

   grouped_query_attention_step dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor: updates the store mirror and queues the result words
   // ---------------------------------------------------------------
   function automatic void attn_predict(input logic [1:0] act, input logic [1:0] layer,
                                        input logic [6:0] pos, input logic [2:0] head,
                                        input logic [5:0] elem, input logic signed [15:0] smp);
      int                  hw, grp, off, kvoff, base;
      longint              dot, s, maxs, diff, ix, acc, v;
      longint              score [128];
      longint unsigned     esum, num;
      attn_word_t          w;
      hw  = (cfg_width == 0) ? 1 : ((cfg_width > 64) ? 64 : cfg_width);
      grp = (cfg_group == 0) ? 1 : cfg_group;
      case (act)
         ACT_WR_QUERY: query_mem[head * 64 + elem] = smp;
         ACT_WR_KEY, ACT_WR_VALUE: begin
            off = head * hw + elem;
            if (elem < hw && off < 256) begin
               if (act == ACT_WR_KEY) key_mem[(layer * 128 + pos) * 256 + off] = smp;
               else val_mem[(layer * 128 + pos) * 256 + off] = smp;
            end
         end
         default: begin
            kvoff = (head / grp) * hw;
            n_runs++;
            if (head >= cfg_heads || kvoff + hw > 256) begin
               // rejected run: one status word, stores untouched
               n_bad_runs++;
               w.head = head; w.elem = 0; w.value = 0; w.last = 1; w.status = 1;
               pending_words.push_back(w);
            end else begin
               base = layer * 128 * 256 + kvoff;
               maxs = 0;
               for (int t = 0; t <= pos; t++) begin
                  dot = 0;
                  for (int d = 0; d < hw; d++)
                     dot += longint'(query_mem[head * 64 + d]) *
                            longint'(key_mem[base + t * 256 + d]);
                  s = (dot * cfg_scale + (longint'(1) << 23)) >>> 24;
                  if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
                  if (s < -64'sh8000_0000) s = -64'sh8000_0000;
                  score[t] = s;
                  if (t == 0 || s > maxs) maxs = s;
               end
               esum = 0;
               for (int t = 0; t <= pos; t++) begin
                  diff = maxs - score[t];
                  ix = (diff + 512) >>> 10;
                  if (ix > 1023) ix = 1023;
                  score[t] = exp_lut[ix];
                  esum += exp_lut[ix];
               end
               for (int t = 0; t <= pos; t++) begin
                  num = longint'(score[t]) * 65536 + esum / 2;
                  score[t] = num / esum;
               end
               for (int d = 0; d < hw; d++) begin
                  acc = 0;
                  for (int t = 0; t <= pos; t++)
                     acc += score[t] * longint'(val_mem[base + t * 256 + d]);
                  v = (acc + 32768) >>> 16;
                  if (v > 32767) v = 32767;
                  if (v < -32768) v = -32768;
                  w.head = head; w.elem = d; w.value = v;
                  w.last = (d + 1 == hw); w.status = 0;
                  pending_words.push_back(w);
               end
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Sender side: one word per call, random gaps in front of it
   // ---------------------------------------------------------------
   task automatic send_item(input logic [1:0] act, input logic [1:0] layer,
                            input logic [6:0] pos, input logic [2:0] head,
                            input logic [5:0] elem, input logic signed [15:0] smp);
      int gap;
      gap = (!no_idle && !tx_quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action = act; req_layer = layer; req_position = pos;
      req_head = head; req_element = elem; req_sample = smp;
      req_valid = 1'b1;
      // hold the word until it is taken
      do @(posedge clock); while (!req_ready);
      attn_predict(act, layer, pos, head, elem, smp);
      n_items++;
   endtask

   // drop valid and wait until every predicted word has come back
   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int data);
      @(negedge clock);
      csr_write_enable = 1'b1; csr_index = idx; csr_data = data[15:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_HEAD_COUNT:  cfg_heads = data & 15;
         CSR_GROUP_SIZE:  cfg_group = data & 15;
         CSR_HEAD_WIDTH:  cfg_width = data & 127;
         default:         cfg_scale = data & 16'hFFFF;
      endcase
   endtask

   task automatic configure(input int heads, input int group, input int width, input int scale);
      wait_drain();
      write_reg(CSR_HEAD_COUNT, heads);
      write_reg(CSR_GROUP_SIZE, group);
      write_reg(CSR_HEAD_WIDTH, width);
      write_reg(CSR_SCORE_SCALE, scale);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 65535);
         1: return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
         2: return $urandom_range(0, 512) - 256;
         default: return $urandom_range(0, 8192) - 4096;
      endcase
   endfunction

   // write every query, key and value entry a run will read that is still empty
   task automatic fill_run_inputs(input logic [1:0] layer, input logic [2:0] head,
                                  input logic [6:0] pos);
      int hw, grp, kvh, base;
      hw   = (cfg_width == 0) ? 1 : ((cfg_width > 64) ? 64 : cfg_width);
      grp  = (cfg_group == 0) ? 1 : cfg_group;
      kvh  = head / grp;
      base = layer * 128 * 256 + kvh * hw;
      for (int d = 0; d < hw; d++)
         if (!query_mem.exists(head * 64 + d))
            send_item(ACT_WR_QUERY, layer, pos, head, d, rand_sample());
      for (int t = 0; t <= pos; t++)
         for (int d = 0; d < hw; d++) begin
            if (!key_mem.exists(base + t * 256 + d))
               send_item(ACT_WR_KEY, layer, t, kvh, d, rand_sample());
            if (!val_mem.exists(base + t * 256 + d))
               send_item(ACT_WR_VALUE, layer, t, kvh, d, rand_sample());
         end
   endtask

   // ---------------------------------------------------------------
   // Receiver side: random stall bursts, or one long counted hold
   // ---------------------------------------------------------------
   initial begin
      int stall;
      stall = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            stall = 400;
         end else if (stall == 0 && !no_idle && $urandom_range(0, 6) == 0) begin
            stall = $urandom_range(1, 10);
         end
         if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // compare every taken word with the oldest prediction
   always @(posedge clock) begin
      attn_word_t w;
      if (!reset && rsp_valid && rsp_ready) begin
         n_words++;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: head %0d elem %0d value %0d last %0d status %0d",
                        rsp_out_head, rsp_out_element, rsp_out_value, rsp_last, rsp_status);
         end else begin
            w = pending_words.pop_front();
            if (rsp_out_head !== w.head || rsp_out_element !== w.elem ||
                rsp_out_value !== w.value || rsp_last !== w.last ||
                rsp_status !== w.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp h%0d e%0d v%0d l%0d s%0d, got h%0d e%0d v%0d l%0d s%0d",
                           w.head, w.elem, w.value, w.last, w.status, rsp_out_head,
                           rsp_out_element, rsp_out_value, rsp_last, rsp_status);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles, pending_words.size());
         $display("grouped_query_attention_step regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // extreme samples, every action, ignored cache writes, one good run
   task automatic test_directed();
      configure(8, 2, 4, 65535);
      send_item(ACT_WR_QUERY, 0, 0, 7, 63, 16'sh7FFF);
      send_item(ACT_WR_KEY, 3, 127, 7, 3, -16'sh8000);
      send_item(ACT_WR_VALUE, 3, 127, 7, 3, 16'sh7FFF);
      send_item(ACT_WR_KEY, 2, 5, 1, 5, 16'sh1234);     // element past width: ignored
      send_item(ACT_WR_VALUE, 2, 5, 1, 63, -16'sh1234); // ignored too
      send_item(ACT_WR_KEY, 3, 0, 1, 0, -16'sh8000);
      send_item(ACT_WR_VALUE, 3, 0, 1, 0, 16'sh7FFF);
      send_item(ACT_WR_QUERY, 3, 0, 3, 0, -16'sh8000);
      fill_run_inputs(3, 3, 1);
      send_item(ACT_RUN, 3, 1, 3, 0, 0);
      wait_drain();
   endtask

   // rejected runs: head past head_count, key-value head past the cache width
   task automatic test_bad_runs();
      configure(3, 1, 4, 8192);
      send_item(ACT_RUN, 1, 9, 5, 17, 16'sh5555);
      send_item(ACT_RUN, 0, 0, 3, 0, 0);
      configure(0, 0, 127, 0);                          // no heads in use
      send_item(ACT_RUN, 2, 0, 0, 0, 0);
      configure(15, 0, 127, 0);                         // width 64, group 1
      send_item(ACT_RUN, 0, 0, 4, 0, 0);
      send_item(ACT_RUN, 1, 127, 7, 0, 0);
      send_item(ACT_WR_KEY, 0, 0, 4, 0, 16'sh0101);    // past the cache width: ignored
      wait_drain();
   endtask

   // widest head vector with one position, then width 1 over every position
   task automatic test_width_extremes();
      configure(8, 8, 64, $urandom_range(0, 65535));
      fill_run_inputs(1, 7, 0);
      send_item(ACT_RUN, 1, 0, 7, 0, 0);
      configure(8, 15, 127, 65535);
      send_item(ACT_RUN, 1, 0, 5, 0, 0);
      configure(4, 1, 0, 65535);                        // width 0 acts as 1
      fill_run_inputs(2, 2, 127);
      send_item(ACT_RUN, 2, 127, 2, 0, 0);
      send_item(ACT_RUN, 2, 64, 2, 0, 0);
      wait_drain();
   endtask

   // mostly well-formed runs on small shapes, with noise writes and bad runs
   task automatic test_random_traffic(input int target);
      int hw, heads;
      logic [1:0] layer;
      logic [2:0] head;
      logic [6:0] pos;
      while (n_items < target) begin
         heads = $urandom_range(0, 9) == 0 ? $urandom_range(9, 15) : $urandom_range(1, 8);
         hw = $urandom_range(0, 7) == 0 ? $urandom_range(5, 8) : $urandom_range(1, 4);
         if ($urandom_range(0, 9) == 0) hw = 0;
         configure(heads, $urandom_range(0, 9), hw, $urandom_range(0, 65535));
         tx_quiet = ($urandom_range(0, 3) == 0);
         repeat (8) begin
            if ($urandom_range(0, 3) != 0) begin
               layer = $urandom_range(0, 3);
               head = $urandom_range(0, (cfg_heads > 8 ? 8 : cfg_heads) - 1);
               pos = $urandom_range(0, 9) == 0 ? $urandom_range(6, 20) : $urandom_range(0, 5);
               fill_run_inputs(layer, head, pos);
               send_item(ACT_RUN, layer, pos, head, 0, 0);
            end else if (cfg_heads < 8 && $urandom_range(0, 1)) begin
               send_item(ACT_RUN, $urandom_range(0, 3), $urandom_range(0, 127),
                         $urandom_range(cfg_heads, 7), $urandom_range(0, 63), rand_sample());
            end else begin
               repeat (3)
                  send_item($urandom_range(0, 2), $urandom_range(0, 3), $urandom_range(0, 127),
                            $urandom_range(0, 7), $urandom_range(0, 63), rand_sample());
            end
         end
      end
      tx_quiet = 0;
      wait_drain();
   endtask

   // receiver holds off a long stretch while runs keep coming, then drain
   task automatic test_backpressure();
      configure(8, 2, 4, 16384);
      for (int h = 0; h < 4; h++) fill_run_inputs(0, h, 3);
      wait_drain();
      hold_request = 1;
      for (int h = 0; h < 4; h++) send_item(ACT_RUN, 0, 3, h, 0, 0);
      send_item(ACT_WR_VALUE, 0, 2, 0, 1, rand_sample());
      send_item(ACT_RUN, 0, 2, 1, 0, 0);
      wait_drain();
   endtask

   // no idling on either side for the last stretch
   task automatic test_full_rate();
      no_idle = 1;
      configure(8, 4, 3, 40000);
      repeat (6) begin
         fill_run_inputs($urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 4));
         send_item(ACT_RUN, req_layer, req_position, $urandom_range(0, 7), 0, 0);
      end
      send_item(ACT_RUN, 0, 0, 7, 0, 0);
      wait_drain();
   endtask

   initial begin
      longint unsigned a, e;
      // exp(-k/64) table from the Q0.32 recurrence
      a = 64'h1_0000_0000;
      for (int i = 0; i < 1024; i++) begin
         if (i > 0) a = (a * 64'd4228380000 + 64'h8000_0000) >> 32;
         e = (a + 32768) >> 16;
         exp_lut[i] = (e > 65535) ? 16'hFFFF : e[15:0];
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_bad_runs();
      test_width_extremes();
      test_random_traffic(ITEM_TARGET);
      test_backpressure();
      test_full_rate();

      wait_drain();
      repeat (50) @(posedge clock);
      $display("covered %0d words in, %0d runs (%0d rejected), %0d result words, %0d cycles",
               n_items, n_runs, n_bad_runs, n_words, cycles);
      $display("%0d mismatches, %0d predictions left over", mismatches, pending_words.size());
      if (mismatches == 0 && pending_words.size() == 0)
         $display("grouped_query_attention_step regression: pass");
      else
         $display("grouped_query_attention_step regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
rtl/gqa_pkg.sv
rtl/gqa_control.sv
rtl/gqa_datapath.sv
rtl/grouped_query_attention_step.sv
sim/tb_top.sv
